### rtl/core/gafr_pkg.sv
// ----------------------------------------------------------------------------
// Acknowledge frame receiver package
// Shared types and constants for the acknowledge frame receiver.
// ----------------------------------------------------------------------------
package gafr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] ACK_CLASS   = 8'h05;
    localparam logic [7:0] ACK_ID_ACK  = 8'h01;
    localparam logic [7:0] ACK_ID_NAK  = 8'h00;
    localparam logic [7:0] ACK_LEN     = 8'h02;

    // Bytes covered by the checksum: class, id, two length bytes, acked pair.
    localparam logic [IDX_W-1:0] SUM_BYTES  = IDX_W'(6);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
    localparam logic [7:0]  SYNC_GAP_RST    = 8'd20;
    localparam logic [7:0]  FRAME_LIMIT_RST = 8'd50;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_START = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCAN  = 2'd1,
        PH_SYNC2 = 2'd2,
        PH_FRAME = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NAK     = 2'd1,
        ST_BADSUM  = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_ACK_TIMEOUT = 2'd0,
        REG_SYNC_GAP    = 2'd1,
        REG_FRAME_LIMIT = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [15:0] ack_timeout;
        logic [7:0]  sync_gap_limit;
        logic [7:0]  frame_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
        logic [7:0] expected_class;
        logic [7:0] cmd_id;
    } t_item;

endpackage

### rtl/core/gafr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the three timing limits, written through an always-ready port.
// ----------------------------------------------------------------------------
module gafr_cfg_regs
    import gafr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_ACK_TIMEOUT: n_cfg.ack_timeout    = i_cfg_data;
                REG_SYNC_GAP:    n_cfg.sync_gap_limit = i_cfg_data[7:0];
                REG_FRAME_LIMIT: n_cfg.frame_limit    = i_cfg_data[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_timeout    <= ACK_TIMEOUT_RST;
            r_cfg.sync_gap_limit <= SYNC_GAP_RST;
            r_cfg.frame_limit    <= FRAME_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/core/gafr_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one input word and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module gafr_in_reg
    import gafr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_in_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    // A held word that the core cannot take this cycle blocks the input.
    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/core/gafr_core.sv
// ----------------------------------------------------------------------------
// Receiver core
// Sync search, frame capture, Fletcher-8 check and tick based timeouts.
// ----------------------------------------------------------------------------
module gafr_core
    import gafr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_item      i_item,
    input  t_cfg       i_cfg,
    output logic       o_result,
    output logic [1:0] o_status
);

    t_phase           r_phase,   n_phase;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [7:0]       r_gap,     n_gap;
    logic [IDX_W-1:0] r_index,   n_index;
    logic [7:0]       r_want_class, n_want_class;
    logic [7:0]       r_want_id,    n_want_id;
    logic [7:0]       r_sum_a,   n_sum_a;
    logic [7:0]       r_sum_b,   n_sum_b;
    logic [7:0]       r_frame [FRAME_BYTES];

    logic       frame_wr;
    logic       header_ok;
    logic       sum_ok;
    logic [7:0] gap_inc;
    logic [7:0] gap_lim;
    t_phase     tick_phase;
    logic [7:0] rx;

    assign rx = i_item.rx_byte;

    // At the last byte, byte 7 is still on the input and serves as check B.
    assign header_ok = (r_frame[0] == ACK_CLASS)
                    && (r_frame[1] == ACK_ID_ACK || r_frame[1] == ACK_ID_NAK)
                    && (r_frame[2] == ACK_LEN) && (r_frame[3] == 8'd0)
                    && (r_frame[4] == r_want_class) && (r_frame[5] == r_want_id);
    assign sum_ok    = (r_sum_a == r_frame[6]) && (r_sum_b == rx);

    assign gap_inc = (r_gap == 8'hFF) ? r_gap : r_gap + 8'd1;
    assign gap_lim = (r_phase == PH_SYNC2) ? i_cfg.sync_gap_limit : i_cfg.frame_limit;

    always_comb begin
        n_phase      = r_phase;
        n_elapsed    = r_elapsed;
        n_gap        = r_gap;
        n_index      = r_index;
        n_want_class = r_want_class;
        n_want_id    = r_want_id;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        frame_wr     = 1'b0;
        o_result     = 1'b0;
        o_status     = ST_OK;
        tick_phase   = r_phase;

        if (i_take) begin
            case (t_action'(i_item.action))
                ACT_START: begin
                    n_want_class = i_item.expected_class;
                    n_want_id    = i_item.cmd_id;
                    n_elapsed    = 16'd0;
                    n_gap        = 8'd0;
                    n_index      = '0;
                    n_phase      = PH_SCAN;
                end
                ACT_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_elapsed = (r_elapsed == 16'hFFFF) ? r_elapsed
                                                            : r_elapsed + 16'd1;
                        if (r_phase inside {PH_SYNC2, PH_FRAME}) begin
                            n_gap = gap_inc;
                            if (gap_inc >= gap_lim) begin
                                tick_phase = PH_SCAN;
                            end
                        end
                        n_phase = tick_phase;
                        if (tick_phase == PH_SCAN && n_elapsed >= i_cfg.ack_timeout) begin
                            o_result = 1'b1;
                            o_status = ST_TIMEOUT;
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                ACT_BYTE: begin
                    case (r_phase)
                        PH_SCAN: begin
                            if (r_elapsed >= i_cfg.ack_timeout) begin
                                o_result = 1'b1;
                                o_status = ST_TIMEOUT;
                                n_phase  = PH_IDLE;
                            end else if (rx == SYNC_FIRST) begin
                                n_phase = PH_SYNC2;
                                n_gap   = 8'd0;
                            end
                        end
                        PH_SYNC2: begin
                            if (rx == SYNC_SECOND) begin
                                n_phase = PH_FRAME;
                                n_gap   = 8'd0;
                                n_index = '0;
                                n_sum_a = 8'd0;
                                n_sum_b = 8'd0;
                            end else begin
                                n_phase = PH_SCAN;
                            end
                        end
                        PH_FRAME: begin
                            frame_wr = 1'b1;
                            if (r_index < SUM_BYTES) begin
                                n_sum_a = r_sum_a + rx;
                                n_sum_b = r_sum_b + n_sum_a;
                            end
                            if (r_index == LAST_INDEX) begin
                                n_index = '0;
                                if (!header_ok) begin
                                    n_phase = PH_SCAN;
                                end else begin
                                    o_result = 1'b1;
                                    n_phase  = PH_IDLE;
                                    if (!sum_ok) begin
                                        o_status = ST_BADSUM;
                                    end else if (r_frame[1] == ACK_ID_ACK) begin
                                        o_status = ST_OK;
                                    end else begin
                                        o_status = ST_NAK;
                                    end
                                end
                            end else begin
                                n_index = r_index + IDX_W'(1);
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_elapsed    <= 16'd0;
            r_gap        <= 8'd0;
            r_index      <= '0;
            r_want_class <= 8'd0;
            r_want_id    <= 8'd0;
            r_sum_a      <= 8'd0;
            r_sum_b      <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_elapsed    <= n_elapsed;
            r_gap        <= n_gap;
            r_index      <= n_index;
            r_want_class <= n_want_class;
            r_want_id    <= n_want_id;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_wr) begin
            r_frame[r_index] <= rx;
        end
    end

endmodule

### rtl/core/gafr_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one status word until the downstream side takes it.
// ----------------------------------------------------------------------------
module gafr_out_reg
    import gafr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [1:0] i_status,
    input  logic       i_out_stall,
    output logic       o_ready,
    output logic       o_out_valid,
    output logic [1:0] o_status
);

    logic       r_valid;
    logic [1:0] r_status;

    // Free now, or about to be emptied at this edge.
    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_status;
        end
    end

endmodule

### rtl/core/gnss_ack_frame_receiver.sv
// ----------------------------------------------------------------------------
// GNSS acknowledge frame receiver
// Waits for an acknowledge frame that answers a sent command and reports it.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  in       | to block  | i_in_valid / o_in_stall  | action, rx_byte, class, id
//  out      | from block| o_out_valid / i_out_stall| status
//  cfg      | to block  | i_cfg_valid / o_cfg_ready| index, data
//
//  Every word passes the input register, then goes through the receiver state
//  logic into the result register. A new word is taken every cycle unless a
//  stalled result blocks it. Reset is synchronous and clears all control
//  state; the configuration port is always ready. A stalled result holds the
//  output register, and one more input word then waits in the input register.
// ----------------------------------------------------------------------------
module gnss_ack_frame_receiver
    import gafr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_expected_class,
    input  logic [7:0]  i_cmd_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       cfg;
    t_item      in_item;
    t_item      held_item;
    logic       held_valid;
    logic       out_ready;
    logic       take;
    logic       result;
    logic [1:0] status;

    assign in_item.action         = i_action;
    assign in_item.rx_byte        = i_rx_byte;
    assign in_item.expected_class = i_expected_class;
    assign in_item.cmd_id         = i_cmd_id;

    assign take = held_valid && out_ready;

    gafr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    gafr_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (in_item),
        .i_take     (take),
        .o_in_stall (o_in_stall),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    gafr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (result),
        .o_status (status)
    );

    gafr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (result),
        .i_status    (status),
        .i_out_stall (i_out_stall),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (o_status)
    );

endmodule

### bench/gafr_status_checker.sv
// ----------------------------------------------------------------------------
// Acknowledge frame receiver status checker
// Watches the input, result and configuration channels of the receiver, keeps
// its own model of the frame scanner and compares every status word that
// leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module gafr_status_checker
    import gafr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_expected_class,
    input  logic [7:0]  i_cmd_id,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    t_cfg             limits;
    t_phase           rx_phase;
    logic [15:0]      elapsed_ms;
    logic [7:0]       gap_ms;
    logic [IDX_W-1:0] frame_pos;
    logic [7:0]       frame_buf [FRAME_BYTES];
    logic [7:0]       want_cls;
    logic [7:0]       want_msg_id;
    logic [7:0]       fsum_a;
    logic [7:0]       fsum_b;
    t_status          status_due [$];
    t_status          due_st;
    int               mismatches = 0;

    assign o_errors = mismatches;

    task automatic report_status(input t_status st);
        status_due.push_back(st);
        rx_phase = PH_IDLE;
    endtask

    // A frame that does not answer the armed command is dropped silently.
    task automatic close_frame();
        if (frame_buf[0] != ACK_CLASS ||
            (frame_buf[1] != ACK_ID_ACK && frame_buf[1] != ACK_ID_NAK) ||
            frame_buf[2] != ACK_LEN || frame_buf[3] != 8'h00 ||
            frame_buf[4] != want_cls || frame_buf[5] != want_msg_id) begin
            rx_phase = PH_SCAN;
        end else if (fsum_a != frame_buf[6] || fsum_b != frame_buf[7]) begin
            report_status(ST_BADSUM);
        end else if (frame_buf[1] == ACK_ID_ACK) begin
            report_status(ST_OK);
        end else begin
            report_status(ST_NAK);
        end
    endtask

    task automatic advance_receiver(input logic [1:0] act, input logic [7:0] rx,
                                    input logic [7:0] cls, input logic [7:0] id);
        logic [7:0] lim;
        if (act == ACT_START) begin
            want_cls    = cls;
            want_msg_id = id;
            elapsed_ms  = '0;
            gap_ms      = '0;
            frame_pos   = '0;
            rx_phase    = PH_SCAN;
        end else if (rx_phase != PH_IDLE && act == ACT_TICK) begin
            if (elapsed_ms != 16'hFFFF) begin
                elapsed_ms = elapsed_ms + 16'd1;
            end
            if (rx_phase == PH_SYNC2 || rx_phase == PH_FRAME) begin
                lim = (rx_phase == PH_SYNC2) ? limits.sync_gap_limit : limits.frame_limit;
                if (gap_ms != 8'hFF) begin
                    gap_ms = gap_ms + 8'd1;
                end
                if (gap_ms >= lim) begin
                    rx_phase = PH_SCAN;
                end
            end
            // The overall timeout is only looked at once the scanner is hunting.
            if (rx_phase == PH_SCAN && elapsed_ms >= limits.ack_timeout) begin
                report_status(ST_TIMEOUT);
            end
        end else if (rx_phase != PH_IDLE && act == ACT_BYTE) begin
            case (rx_phase)
                PH_SCAN: begin
                    if (elapsed_ms >= limits.ack_timeout) begin
                        report_status(ST_TIMEOUT);
                    end else if (rx == SYNC_FIRST) begin
                        rx_phase = PH_SYNC2;
                        gap_ms   = '0;
                    end
                end
                PH_SYNC2: begin
                    if (rx == SYNC_SECOND) begin
                        rx_phase  = PH_FRAME;
                        gap_ms    = '0;
                        frame_pos = '0;
                        fsum_a    = '0;
                        fsum_b    = '0;
                    end else begin
                        rx_phase = PH_SCAN;
                    end
                end
                PH_FRAME: begin
                    frame_buf[frame_pos] = rx;
                    if (frame_pos < SUM_BYTES) begin
                        fsum_a = fsum_a + rx;
                        fsum_b = fsum_b + fsum_a;
                    end
                    if (frame_pos == LAST_INDEX) begin
                        frame_pos = '0;
                        close_frame();
                    end else begin
                        frame_pos = frame_pos + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limits.ack_timeout    = ACK_TIMEOUT_RST;
            limits.sync_gap_limit = SYNC_GAP_RST;
            limits.frame_limit    = FRAME_LIMIT_RST;
            rx_phase              = PH_IDLE;
            elapsed_ms            = '0;
            gap_ms                = '0;
            frame_pos             = '0;
            want_cls              = '0;
            want_msg_id           = '0;
            fsum_a                = '0;
            fsum_b                = '0;
            status_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACK_TIMEOUT: limits.ack_timeout    = i_cfg_data;
                    REG_SYNC_GAP:    limits.sync_gap_limit = i_cfg_data[7:0];
                    REG_FRAME_LIMIT: limits.frame_limit    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Results trail their input word, so compare first.
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $display("%0t: status word with none pending, expected none, actual %0d",
                             $time, i_status);
                    mismatches <= mismatches + 1;
                end else begin
                    due_st = status_due.pop_front();
                    if (i_status !== due_st) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, due_st, i_status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_receiver(i_action, i_rx_byte, i_expected_class, i_cmd_id);
            end
        end
        o_pending <= status_due.size();
    end

endmodule

### bench/tb_gnss_ack_frame_receiver.sv
// ----------------------------------------------------------------------------
// Acknowledge frame receiver testbench
// Drives byte, tick, start and idle words into the receiver under several
// timeout settings, with bursty input and a randomly stalling result side. A
// checker beside the block predicts every status word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_gnss_ack_frame_receiver;
    import gafr_pkg::*;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action         = ACT_NONE;
    logic [7:0]  i_rx_byte        = 8'h00;
    logic [7:0]  i_expected_class = 8'h00;
    logic [7:0]  i_cmd_id         = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [1:0]  o_status;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index      = REG_ACK_TIMEOUT;
    logic [15:0] i_cfg_data       = 16'h0000;

    int errors;
    int pending;
    int words_sent  = 0;
    int burst_left  = 10;
    int hold_asked  = 0;
    int hold_served = 0;

    gnss_ack_frame_receiver i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_rx_byte        (i_rx_byte),
        .i_expected_class (i_expected_class),
        .i_cmd_id         (i_cmd_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    gafr_status_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_rx_byte        (i_rx_byte),
        .i_expected_class (i_expected_class),
        .i_cmd_id         (i_cmd_id),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: stall rate changes every so often; a requested hold-off
    // keeps the result channel blocked long enough to back up the input.
    initial begin : result_stall
        int stall_pct;
        int stretch_left;
        stall_pct    = 0;
        stretch_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else begin
                if (stretch_left == 0) begin
                    stall_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
                    stretch_left = $urandom_range(20, 200);
                end
                stretch_left--;
                i_out_stall <= ($urandom_range(1, 100) <= stall_pct);
            end
        end
    end

    task automatic send_word(input t_action act, input logic [7:0] rx,
                             input logic [7:0] cls, input logic [7:0] id);
        i_action         <= act;
        i_rx_byte        <= rx;
        i_expected_class <= cls;
        i_cmd_id         <= id;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (act != ACT_NONE) begin
            words_sent++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_word(ACT_BYTE, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic put_tick();
        send_word(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic put_start(input logic [7:0] cls, input logic [7:0] id);
        send_word(ACT_START, 8'($urandom_range(0, 255)), cls, id);
    endtask

    task automatic put_idle_word();
        send_word(ACT_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // Six header bytes, lowest byte first, followed by the two check bytes.
    function automatic logic [63:0] make_frame(input logic [47:0] head);
        logic [7:0] ca;
        logic [7:0] cb;
        ca = 8'h00;
        cb = 8'h00;
        for (int k = 0; k < 6; k++) begin
            ca = ca + head[8*k +: 8];
            cb = cb + ca;
        end
        return {cb, ca, head};
    endfunction

    task automatic put_frame(input logic [63:0] fr, input bit with_ticks);
        put_byte(SYNC_FIRST);
        if (with_ticks && $urandom_range(0, 7) == 0) begin
            put_tick();
        end
        put_byte(SYNC_SECOND);
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (with_ticks && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) put_tick();
            end
            put_byte(fr[8*k +: 8]);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic wait_cfg();
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Upper data bits of the 8-bit limits are filled with noise on purpose.
    task automatic apply_limits(input logic [15:0] ack_lim, input logic [7:0] gap_lim,
                                input logic [7:0] frame_lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ACK_TIMEOUT;
        i_cfg_data  <= ack_lim;
        wait_cfg();
        i_cfg_index <= REG_SYNC_GAP;
        i_cfg_data  <= {8'($urandom_range(0, 255)), gap_lim};
        wait_cfg();
        i_cfg_index <= REG_FRAME_LIMIT;
        i_cfg_data  <= {8'($urandom_range(0, 255)), frame_lim};
        wait_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    // One command exchange: arm, some line noise, then usually a frame that
    // mostly answers the command, now and then with a broken field or sum.
    task automatic run_exchange();
        logic [7:0]  wc;
        logic [7:0]  wi;
        logic [7:0]  fc;
        logic [7:0]  fi;
        logic [7:0]  ac;
        logic [7:0]  ai;
        logic [7:0]  l0;
        logic [7:0]  l1;
        logic [63:0] fr;
        wc = ($urandom_range(0, 3) == 0) ? 8'h06 : 8'($urandom_range(0, 255));
        wi = 8'($urandom_range(0, 255));
        put_start(wc, wi);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0: put_byte(8'($urandom_range(0, 255)));
                1: begin
                    put_byte(SYNC_FIRST);
                    put_byte(8'($urandom_range(0, 255)));
                end
                2: begin
                    put_byte(SYNC_FIRST);
                    put_byte(SYNC_FIRST);
                end
                3: repeat ($urandom_range(1, 4)) put_tick();
                4: put_idle_word();
                default: put_byte(SYNC_SECOND);
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(5, 80)) put_tick();
        end
        if ($urandom_range(0, 9) != 0) begin
            fc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : ACK_CLASS;
            if ($urandom_range(0, 9) == 0) begin
                fi = 8'($urandom_range(0, 255));
            end else begin
                fi = $urandom_range(0, 1) ? ACK_ID_ACK : ACK_ID_NAK;
            end
            if ($urandom_range(0, 11) == 0) begin
                l0 = 8'($urandom_range(0, 255));
                l1 = 8'($urandom_range(0, 255));
            end else begin
                l0 = ACK_LEN;
                l1 = 8'h00;
            end
            ac = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : wc;
            ai = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : wi;
            fr = make_frame({ai, ac, l1, l0, fi, fc});
            if ($urandom_range(0, 4) == 0) begin
                fr[63:48] = fr[63:48] ^ 16'($urandom_range(1, 65535));
            end
            put_frame(fr, 1'b1);
        end
        if ($urandom_range(0, 5) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int phase_end;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Words while idle are dropped, as is the unused action.
        put_byte(SYNC_FIRST);
        put_tick();
        put_idle_word();
        // Re-arming between the sync bytes, then a lone first sync byte
        // followed by another one, which is consumed.
        put_start(8'h11, 8'h22);
        put_byte(SYNC_FIRST);
        put_start(8'h06, 8'h01);
        put_byte(SYNC_FIRST);
        put_byte(SYNC_FIRST);
        put_frame(make_frame({8'h01, 8'h06, 8'h00, ACK_LEN, ACK_ID_ACK, ACK_CLASS}), 1'b0);
        put_start(8'hFF, 8'hFF);
        put_frame(make_frame({8'hFF, 8'hFF, 8'h00, ACK_LEN, ACK_ID_NAK, ACK_CLASS}) ^
                  {8'h01, 56'h0}, 1'b0);

        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                0: apply_limits(ACK_TIMEOUT_RST, SYNC_GAP_RST, FRAME_LIMIT_RST);
                1: apply_limits(16'hFFFF, 8'hFF, 8'hFF);
                2: apply_limits(16'($urandom_range(3, 40)), 8'h00, 8'h00);
                3: apply_limits(16'($urandom_range(20, 200)), 8'($urandom_range(1, 4)),
                                8'($urandom_range(2, 8)));
                4: apply_limits(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                5: apply_limits(16'd1, 8'd1, 8'd1);
                6: apply_limits(16'($urandom_range(5, 60)), SYNC_GAP_RST, FRAME_LIMIT_RST);
                default: apply_limits(16'($urandom_range(0, 300)), 8'($urandom_range(0, 30)),
                                      8'($urandom_range(0, 60)));
            endcase
            if (p == 4) begin
                // With a zero timeout every armed byte or tick ends in a timeout,
                // so a long result hold-off backs the block up to its input.
                settle();
                apply_limits(16'd0, SYNC_GAP_RST, FRAME_LIMIT_RST);
                hold_asked++;
                repeat (40) begin
                    put_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1)) begin
                        put_byte(8'($urandom_range(0, 255)));
                    end else begin
                        put_tick();
                    end
                end
                settle();
                apply_limits(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            end
            phase_end = words_sent + 225;
            while (words_sent < phase_end) begin
                run_exchange();
            end
        end

        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/gafr_pkg.sv
rtl/core/gafr_cfg_regs.sv
rtl/core/gafr_in_reg.sv
rtl/core/gafr_core.sv
rtl/core/gafr_out_reg.sv
rtl/core/gnss_ack_frame_receiver.sv
bench/gafr_status_checker.sv
bench/tb_gnss_ack_frame_receiver.sv
